### design/mpq_pkg.sv
// Shared constants, codes and control types for the max priority queue.
`timescale 1ns / 1ps

package mpq_pkg;

    // Storage geometry
    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Output field widths
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 6;

    // Command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    // Status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE,
        ST_FINISH
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic ins_write;
        logic scan_start;
        logic scan_issue;
        logic del_write;
        logic load_out;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_delete;
        logic empty;
        logic scan_last;
        logic out_free;
    } dp_stat_t;

endpackage

### design/mpq_ctrl.sv
// Controller state machine for the max priority queue.
`timescale 1ns / 1ps

module mpq_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mpq_pkg::dp_stat_t stat,
    output mpq_pkg::dp_cmd_t  cmd
);

    mpq_pkg::state_t state_reg;
    mpq_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mpq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            mpq_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = mpq_pkg::ST_EXEC;
                end
            end
            mpq_pkg::ST_EXEC:
            begin
                if (!stat.is_delete)
                begin
                    cmd.ins_write = 1'b1;
                    state_next    = mpq_pkg::ST_FINISH;
                end
                else if (!stat.empty)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = mpq_pkg::ST_SCAN;
                end
                else
                begin
                    state_next = mpq_pkg::ST_FINISH;
                end
            end
            mpq_pkg::ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = mpq_pkg::ST_DRAIN;
                end
            end
            mpq_pkg::ST_DRAIN:
            begin
                // last read word is compared at the end of this cycle
                state_next = mpq_pkg::ST_WRITE;
            end
            mpq_pkg::ST_WRITE:
            begin
                cmd.del_write = 1'b1;
                state_next    = mpq_pkg::ST_FINISH;
            end
            mpq_pkg::ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = mpq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mpq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### design/mpq_dpath.sv
// Datapath for the max priority queue: entry memory, count, scan and result registers.
`timescale 1ns / 1ps

module mpq_dpath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  mpq_pkg::dp_cmd_t                    cmd,
    output mpq_pkg::dp_stat_t                   stat,
    input  logic                                command,
    input  logic signed [mpq_pkg::DATA_W-1:0]   value,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic signed [mpq_pkg::DATA_W-1:0]   result_value,
    output logic [1:0]                          status,
    output logic [mpq_pkg::COUNT_W-1:0]         entry_count
);

    // Entry memory
    logic signed [mpq_pkg::DATA_W-1:0] mem [mpq_pkg::CAPACITY];

    // Latched item
    logic                              cmd_reg;
    logic signed [mpq_pkg::DATA_W-1:0] val_reg;
    logic [1:0]                        err_reg;
    logic [1:0]                        err_next;

    // Count and scan state
    logic [mpq_pkg::CNT_W-1:0]         count_reg;
    logic [mpq_pkg::IDX_W-1:0]         rd_addr_reg;
    logic signed [mpq_pkg::DATA_W-1:0] rd_data_reg;
    logic [mpq_pkg::IDX_W-1:0]         cmp_idx_reg;
    logic                              cmp_valid_reg;
    logic signed [mpq_pkg::DATA_W-1:0] best_reg;
    logic [mpq_pkg::IDX_W-1:0]         where_reg;
    logic signed [mpq_pkg::DATA_W-1:0] last_reg;

    // Output register
    logic                              out_valid_reg;
    logic signed [mpq_pkg::DATA_W-1:0] result_value_reg;
    logic [1:0]                        status_reg;
    logic [mpq_pkg::COUNT_W-1:0]       entry_count_reg;

    logic                              full;
    logic                              empty;
    logic [mpq_pkg::CNT_W-1:0]         count_minus1;
    logic [mpq_pkg::CNT_W-1:0]         rd_addr_ext;
    logic                              mem_we;
    logic [mpq_pkg::IDX_W-1:0]         mem_waddr;
    logic signed [mpq_pkg::DATA_W-1:0] mem_wdata;
    logic [mpq_pkg::CNT_W+mpq_pkg::COUNT_W-1:0] count_wide;
    logic signed [mpq_pkg::DATA_W-1:0] res_value;
    logic [1:0]                        res_status;

    assign full         = (count_reg == mpq_pkg::CNT_W'(mpq_pkg::CAPACITY));
    assign empty        = (count_reg == '0);
    assign count_minus1 = count_reg - mpq_pkg::CNT_W'(1);
    assign rd_addr_ext  = mpq_pkg::CNT_W'(rd_addr_reg);
    assign count_wide   = {{mpq_pkg::COUNT_W{1'b0}}, count_reg};

    // Status back to the controller
    always_comb
    begin
        stat.is_delete = (cmd_reg == mpq_pkg::CMD_DELETE);
        stat.empty     = empty;
        stat.scan_last = (rd_addr_ext == count_minus1);
        stat.out_free  = !out_valid_reg || out_ready;
    end

    // Error code decided on the count seen at acceptance, before it moves
    always_comb
    begin
        err_next = mpq_pkg::STATUS_OK;
        if (command == mpq_pkg::CMD_DELETE)
        begin
            if (empty)
            begin
                err_next = mpq_pkg::STATUS_EMPTY;
            end
        end
        else if (full)
        begin
            err_next = mpq_pkg::STATUS_FULL;
        end
    end

    // Memory write port: append on insert, gap fill on delete
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = count_reg[mpq_pkg::IDX_W-1:0];
        mem_wdata = val_reg;
        if (cmd.ins_write && !full)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.del_write)
        begin
            mem_we    = 1'b1;
            mem_waddr = where_reg;
            mem_wdata = last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    // Registered memory read during the scan
    always_ff @(posedge clk)
    begin
        if (cmd.scan_issue)
        begin
            rd_data_reg <= mem[rd_addr_reg];
            cmp_idx_reg <= rd_addr_reg;
        end
    end

    // Item latch, scan address, running maximum
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cmd_reg <= command;
            val_reg <= value;
            err_reg <= err_next;
        end
        if (cmd.scan_start)
        begin
            rd_addr_reg <= '0;
        end
        else if (cmd.scan_issue)
        begin
            rd_addr_reg <= rd_addr_reg + mpq_pkg::IDX_W'(1);
        end
        if (cmp_valid_reg)
        begin
            // first index always taken, later ones only if strictly larger
            if (cmp_idx_reg == '0 || rd_data_reg > best_reg)
            begin
                best_reg  <= rd_data_reg;
                where_reg <= cmp_idx_reg;
            end
            last_reg <= rd_data_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= cmd.scan_issue;
            if (cmd.ins_write && !full)
            begin
                count_reg <= count_reg + mpq_pkg::CNT_W'(1);
            end
            else if (cmd.del_write)
            begin
                count_reg <= count_minus1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result selection
    always_comb
    begin
        res_value  = '0;
        res_status = err_reg;
        if (err_reg == mpq_pkg::STATUS_OK)
        begin
            if (cmd_reg == mpq_pkg::CMD_DELETE)
            begin
                res_value = best_reg;
            end
            else
            begin
                res_value = val_reg;
            end
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            result_value_reg <= res_value;
            status_reg       <= res_status;
            entry_count_reg  <= count_wide[mpq_pkg::COUNT_W-1:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_value_reg;
    assign status       = status_reg;
    assign entry_count  = entry_count_reg;

endmodule

### design/max_priority_queue_linear_scan.sv
// Top level of the bounded max priority queue with linear-scan delete.
//
//  channel | handshake            | fields
//  --------+----------------------+-------------------------------------------
//  input   | in_valid / in_ready  | command, value
//  output  | out_valid / out_ready| result_value, status, entry_count
//
// An insert goes from acceptance through the execute and finish steps to its result;
// a delete goes through execute, a scan that reads one stored entry a cycle from
// the memory, drain, write and finish (a delete on an empty queue skips to finish).
// One item is worked on at a time; in_ready is high only while the block idles.
// A result sits in the output register until taken; a stalled output holds
// the next result in the finish step. Reset clears the count; the entry
// memory is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module max_priority_queue_linear_scan
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                command,
    input  logic signed [mpq_pkg::DATA_W-1:0]   value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [mpq_pkg::DATA_W-1:0]   result_value,
    output logic [1:0]                          status,
    output logic [mpq_pkg::COUNT_W-1:0]         entry_count
);

    mpq_pkg::dp_cmd_t  dp_cmd;
    mpq_pkg::dp_stat_t dp_stat;

    // Sequencer
    mpq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    // Storage and compare
    mpq_dpath u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (dp_cmd),
        .stat         (dp_stat),
        .command      (command),
        .value        (value),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .result_value (result_value),
        .status       (status),
        .entry_count  (entry_count)
    );

endmodule
